// ----- sv/bsr_pkg.sv -----
`default_nettype none

package bsr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned SqW   = 48;

  // 1.0 in Q16.16
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;

  // Power-on tolerance, about 0.001 in Q16.16
  localparam logic [DataW-1:0] TolReset = 32'd66;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_CMP  = 3'b100
  } bsr_state_e;

  // Comparator verdict from the shared step unit
  typedef struct packed {
    logic over;  // squared midpoint above the number
    logic done;  // |square - number| within tolerance
  } bsr_cmp_t;

endpackage

`default_nettype wire

// ----- sv/bsr_in_if.sv -----
`default_nettype none

interface bsr_in_if;
  import bsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// ----- sv/bsr_out_if.sv -----
`default_nettype none

interface bsr_out_if;
  import bsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] midpoint;
  logic             last;
  logic             bad_input;
  logic             limit_hit;

  modport source (output valid, output midpoint, output last, output bad_input,
                  output limit_hit, input ready);
  modport sink   (input valid, input midpoint, input last, input bad_input,
                  input limit_hit, output ready);
endinterface

`default_nettype wire

// ----- sv/bsr_step_unit.sv -----
`default_nettype none

module bsr_step_unit
  import bsr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DataW-1:0] lo_i,
  input  wire logic [DataW-1:0] hi_i,
  input  wire logic [DataW-1:0] number_i,
  input  wire logic [DataW-1:0] tol_i,
  output logic      [DataW-1:0] mid_o,
  output bsr_cmp_t              cmp_o
);

  logic [DataW:0]     sum;
  logic [DataW-1:0]   mid;
  logic [2*DataW-1:0] prod;
  logic [DataW-1:0]   mid_q;
  logic [SqW-1:0]     sq_q;
  logic [SqW-1:0]     num_ext;
  logic [SqW-1:0]     diff;

  assign sum  = {1'b0, lo_i} + {1'b0, hi_i};
  assign mid  = sum[DataW:1];
  assign prod = mid * mid;

  // midpoint and truncated Q32.16 square, registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid;
      sq_q  <= prod[2*DataW-1:16];
    end
  end

  assign num_ext    = {{(SqW-DataW){1'b0}}, number_i};
  assign cmp_o.over = sq_q > num_ext;
  assign diff       = cmp_o.over ? (sq_q - num_ext) : (num_ext - sq_q);
  assign cmp_o.done = diff <= {{(SqW-DataW){1'b0}}, tol_i};
  assign mid_o      = mid_q;

endmodule

`default_nettype wire

// ----- sv/bisection_square_root.sv -----
// Bisection: each step squares the midpoint (S_MUL), then compares (S_CMP), so
//   a number takes 1 to MAX_STEPS steps to its last result; zero takes one compare.
// Results: the one shared square-and-compare unit serves every step, and a step
//   waits in S_CMP while the output register is still full. A new number is taken
//   only once the last result of the previous one is in the output register.
// Reset (rst_ni, async, active low): sequencer idle, output empty, tolerance 66.
`default_nettype none

module bisection_square_root
  import bsr_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DataW-1:0] cfg_wdata_i,
  bsr_in_if.sink                in_i,
  bsr_out_if.source             out_o
);

  localparam int unsigned StepW = $clog2(MAX_STEPS);

  bsr_state_e       state_q, state_d;
  logic [DataW-1:0] tol_q;
  logic [DataW-1:0] num_q, num_d;
  logic [DataW-1:0] lo_q, lo_d;
  logic [DataW-1:0] hi_q, hi_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             bad_q, bad_d;

  // output register
  logic             ov_q, ov_d;
  logic [DataW-1:0] omid_q;
  logic             olast_q, obad_q, olim_q;

  logic             in_txn;
  logic             out_free;
  logic             load;
  logic             final_step;
  logic [DataW-1:0] mid;
  bsr_cmp_t         cmp;
  logic [DataW-1:0] rmid;
  logic             rlast, rbad, rlim;

  // Tolerance register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  bsr_step_unit u_step (
    .clk_i    (clk_i),
    .en_i     (state_q == S_MUL),
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .number_i (num_q),
    .tol_i    (tol_q),
    .mid_o    (mid),
    .cmp_o    (cmp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_txn     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;
  assign final_step = (cnt_q == StepW'(MAX_STEPS - 1));

  // Result of the current compare; a zero number gives the error result
  always_comb begin
    if (bad_q) begin
      rmid  = '0;
      rlast = 1'b1;
      rbad  = 1'b1;
      rlim  = 1'b0;
    end else begin
      rmid  = mid;
      rlast = cmp.done || final_step;
      rbad  = 1'b0;
      rlim  = !cmp.done && final_step;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    cnt_d   = cnt_q;
    bad_d   = bad_q;
    load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_txn) begin
          num_d   = in_i.number;
          lo_d    = '0;
          hi_d    = (in_i.number > OneQ16) ? in_i.number : OneQ16;
          cnt_d   = '0;
          bad_d   = (in_i.number == '0);
          state_d = (in_i.number == '0) ? S_CMP : S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        // wait here while the output register is still full
        if (out_free) begin
          load = 1'b1;
          if (rlast) begin
            state_d = S_IDLE;
          end else begin
            if (cmp.over) begin
              hi_d = mid;
            end else begin
              lo_d = mid;
            end
            cnt_d   = cnt_q + 1'b1;
            state_d = S_MUL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ov_d = load || (ov_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    if (load) begin
      omid_q  <= rmid;
      olast_q <= rlast;
      obad_q  <= rbad;
      olim_q  <= rlim;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.midpoint  = omid_q;
  assign out_o.last      = olast_q;
  assign out_o.bad_input = obad_q;
  assign out_o.limit_hit = olim_q;

`ifndef SYNTHESIS
  a_bad_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_input |-> out_o.last && (out_o.midpoint == '0))
    else $error("error result must be last with zero midpoint");

  a_limit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.limit_hit |-> out_o.last && !out_o.bad_input)
    else $error("limit flag without last");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cnt_q <= StepW'(MAX_STEPS - 1)))
    else $error("step counter passed the limit");

  a_busy_after_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_txn |=> !in_i.ready)
    else $error("input taken again before the search finished");

  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_o.valid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
